FILE: hdl/tpd_pkg.sv
// ----------------------------------------------------------------------------
// tpd_pkg
// Shared types, template tables and match helpers for the template packet
// deframer.
// ----------------------------------------------------------------------------
package tpd_pkg;

	// capture store depth and index width
	localparam int MAX_PACKET_BYTES = 24;
	localparam int CAP_AW           = $clog2(MAX_PACKET_BYTES);
	localparam int POS_W            = 5;

	// template lengths
	localparam logic [POS_W-1:0] IDENT_LEN   = 5'd12;
	localparam logic [POS_W-1:0] KEYS_LEN    = 5'd2;
	localparam logic [POS_W-1:0] ROUTING_LEN = 5'd24;

	// template element codes: exact bytes are 8'hxx, wildcards sit above them
	localparam logic [8:0] M_ANY   = 9'h100;
	localparam logic [8:0] M_DIGIT = 9'h101;
	localparam logic [8:0] M_KEY   = 9'h102;

	localparam logic [7:0] CELL_DEFAULT = 8'h28;

	typedef enum logic [1:0] {
		TT_IDENTITY = 2'd0,
		TT_KEYS     = 2'd1,
		TT_ROUTING  = 2'd2
	} template_t;

	localparam logic [8:0] TMPL_IDENT_OLD [12] = '{
		9'h000, 9'h005, 9'h028, 9'h008, 9'h076, M_DIGIT, 9'h02E, M_DIGIT,
		9'h001, 9'h001, 9'h001, 9'h001
	};

	localparam logic [8:0] TMPL_IDENT_NEW [12] = '{
		9'h073, 9'h065, 9'h069, 9'h06B, 9'h061, M_DIGIT,
		9'h020, 9'h076, M_DIGIT, 9'h02E, M_DIGIT, M_DIGIT
	};

	localparam logic [8:0] TMPL_ROUTING [24] = '{
		9'h000, 9'h008, 9'h009, 9'h000, 9'h000, 9'h000, 9'h000,
		M_ANY, M_ANY, M_ANY, M_ANY, M_ANY,
		9'h000, 9'h008, 9'h009, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000
	};

	typedef struct packed {
		logic       kind;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  packet_type;
		logic [12:0] key_bits;
		logic [39:0] routing_bits;
		logic [11:0] firmware_version;
		logic [3:0]  model_number;
		logic [7:0]  cell_count;
	} out_item_t;

	typedef logic [MAX_PACKET_BYTES-1:0][7:0] cap_t;

	// state update and capture control from the step logic
	typedef struct packed {
		logic             emit;
		logic             wr_en;
		logic [POS_W-1:0] wr_pos;
		logic [POS_W-1:0] pos_next;
		template_t        tmpl_next;
	} step_ctl_t;

	function automatic logic [POS_W-1:0] tmpl_len(template_t t);
		logic [POS_W-1:0] len;
		case (t)
			TT_KEYS:    len = KEYS_LEN;
			TT_ROUTING: len = ROUTING_LEN;
			default:    len = IDENT_LEN;
		endcase
		return len;
	endfunction

	// element expected at a position; past the end anything goes
	function automatic logic [8:0] tmpl_elem(logic variant, template_t t,
		logic [POS_W-1:0] pos);
		logic [8:0] e;
		e = M_ANY;
		case (t)
			TT_KEYS: begin
				if (pos < KEYS_LEN) e = M_KEY;
			end
			TT_ROUTING: begin
				if (pos < ROUTING_LEN) e = TMPL_ROUTING[pos];
			end
			TT_IDENTITY: begin
				if (pos < IDENT_LEN)
					e = variant ? TMPL_IDENT_NEW[pos[3:0]] : TMPL_IDENT_OLD[pos[3:0]];
			end
			default: e = M_ANY;
		endcase
		return e;
	endfunction

	function automatic logic tmpl_match(logic variant, template_t t,
		logic [POS_W-1:0] pos, logic [7:0] b);
		logic [8:0] e;
		logic       ok;
		e = tmpl_elem(variant, t, pos);
		case (e)
			M_ANY:   ok = 1'b1;
			M_DIGIT: ok = b inside {[8'h30:8'h39]};
			M_KEY:   ok = (b[7:5] == 3'b111);
			default: ok = (b == e[7:0]);
		endcase
		return ok;
	endfunction

	// decimal digit value of an ASCII byte, zero if not a digit
	function automatic logic [3:0] digit_of(logic [7:0] c);
		return (c inside {[8'h30:8'h39]}) ? c[3:0] : 4'h0;
	endfunction

endpackage

FILE: hdl/tpd_step.sv
// ----------------------------------------------------------------------------
// tpd_step
// Per-byte template match, state update and result assembly for one item.
// ----------------------------------------------------------------------------
module tpd_step (
	input  tpd_pkg::in_item_t               item,
	input  logic                            variant,
	input  logic [tpd_pkg::POS_W-1:0]       pos,
	input  tpd_pkg::template_t              tmpl,
	input  tpd_pkg::cap_t                   cap,
	output tpd_pkg::step_ctl_t              ctl,
	output tpd_pkg::out_item_t              result
);

	logic [tpd_pkg::POS_W-1:0] p;
	logic [tpd_pkg::POS_W-1:0] pn;
	tpd_pkg::template_t        tt;
	logic                      ok;
	logic                      take;
	logic [7:0]                b;
	tpd_pkg::cap_t             cap_n;
	logic [8:0]                id_start;

	assign b        = item.rx_byte;
	assign id_start = tpd_pkg::tmpl_elem(variant, tpd_pkg::TT_IDENTITY, '0);

	// match the byte, fall back to the alternate template, restart on failure
	always_comb begin
		p    = pos;
		tt   = tmpl;
		ok   = 1'b1;
		take = 1'b0;
		pn   = '0;
		ctl  = '{emit: 1'b0, wr_en: 1'b0, wr_pos: '0, pos_next: '0,
			tmpl_next: tmpl};
		if (!item.kind) begin
			if (p != '0) begin
				ok = tpd_pkg::tmpl_match(variant, tt, p, b);
				if (!ok && p == 5'd1 && tt == tpd_pkg::TT_IDENTITY) begin
					tt = variant ? tpd_pkg::TT_KEYS : tpd_pkg::TT_ROUTING;
					ok = tpd_pkg::tmpl_match(variant, tt, p, b);
				end
				if (!ok) p = '0;
			end
			take = 1'b1;
			if (p == '0) begin
				if ({1'b0, b} == id_start) tt = tpd_pkg::TT_IDENTITY;
				else if (b == 8'h00) tt = tpd_pkg::TT_ROUTING;
				else if (b[7:5] == 3'b011) tt = tpd_pkg::TT_KEYS;
				else take = 1'b0;
			end
			if (take) begin
				ctl.wr_en  = ({1'b0, p} < 6'(tpd_pkg::MAX_PACKET_BYTES));
				ctl.wr_pos = p;
				pn         = p + 5'd1;
				if (pn >= tpd_pkg::tmpl_len(tt)) begin
					ctl.emit = 1'b1;
					pn       = '0;
				end
			end
			ctl.pos_next  = take ? pn : '0;
			ctl.tmpl_next = tt;
		end
	end

	// captured bytes with the current byte in place
	always_comb begin
		cap_n = cap;
		if (ctl.wr_en) cap_n[ctl.wr_pos[tpd_pkg::CAP_AW-1:0]] = b;
	end

	// assemble the result for a completed packet
	always_comb begin
		result                  = '0;
		result.packet_type      = tt;
		result.cell_count       = tpd_pkg::CELL_DEFAULT;
		case (tt)
			tpd_pkg::TT_KEYS: begin
				result.key_bits = {cap_n[1][4:0], 3'b000, cap_n[0][4:0]};
			end
			tpd_pkg::TT_ROUTING: begin
				result.routing_bits = {cap_n[11], cap_n[10], cap_n[9], cap_n[8], cap_n[7]};
			end
			tpd_pkg::TT_IDENTITY: begin
				if (variant) begin
					result.firmware_version = {tpd_pkg::digit_of(cap_n[8]),
						tpd_pkg::digit_of(cap_n[10]), tpd_pkg::digit_of(cap_n[11])};
					result.model_number = tpd_pkg::digit_of(cap_n[5]);
				end else begin
					result.firmware_version = {tpd_pkg::digit_of(cap_n[5]),
						tpd_pkg::digit_of(cap_n[7]), 4'h0};
					result.cell_count = cap_n[2];
				end
			end
			default: result.packet_type = tt;
		endcase
	end

endmodule

FILE: hdl/template_packet_deframer_core.sv
// ----------------------------------------------------------------------------
// template_packet_deframer_core
// Byte-stream deframer matching identity, routing and key packet templates.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries one item per transfer:
//   a received byte, or a timeout that drops any partial packet.
//   Output channel (out_valid/out_ready/out_data) carries one result per
//   completed packet: type, key bits, routing bits and identity fields.
//   cfg_we/cfg_wdata write protocol_variant; write it only while idle.
// Timing:
//   An item lands in the input register at its transfer edge; as it leaves,
//   the template compare runs, the parser state updates and the result
//   register loads. One item per cycle is sustained unless a completing item
//   waits behind a held result; the rate is set by the single compare/update
//   pass between the input and result registers, which the byte-position
//   state feeds back into.
// Stall:
//   While a result waits, items that complete no packet still pass; an item
//   that would complete one holds in the input register and in_ready drops.
// Reset:
//   arst_n clears the byte position, the variant and both valid flags.
//   The capture store needs no clearing pass.
// ----------------------------------------------------------------------------
module template_packet_deframer_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tpd_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output tpd_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);

	tpd_pkg::in_item_t         item_s1;
	logic                      valid_s1;
	logic                      variant_q;
	logic [tpd_pkg::POS_W-1:0] pos_q;
	tpd_pkg::template_t        tmpl_q;
	tpd_pkg::cap_t             cap_q;
	tpd_pkg::out_item_t        out_q;
	logic                      out_valid_q;

	tpd_pkg::step_ctl_t        ctl;
	tpd_pkg::out_item_t        result;
	logic                      out_free;
	logic                      s1_adv;

	tpd_step u_step (
		.item    (item_s1),
		.variant (variant_q),
		.pos     (pos_q),
		.tmpl    (tmpl_q),
		.cap     (cap_q),
		.ctl     (ctl),
		.result  (result)
	);

	// advance the input stage unless its result has nowhere to go
	assign out_free  = !out_valid_q || out_ready;
	assign s1_adv    = valid_s1 && (out_free || !ctl.emit);
	assign in_ready  = !valid_s1 || s1_adv;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (cfg_we) begin
			variant_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) item_s1 <= in_data;
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			tmpl_q <= tpd_pkg::TT_IDENTITY;
		end else if (s1_adv) begin
			pos_q  <= ctl.pos_next;
			tmpl_q <= ctl.tmpl_next;
		end
	end

	// capture store
	always_ff @(posedge clk) begin
		if (s1_adv && ctl.wr_en)
			cap_q[ctl.wr_pos[tpd_pkg::CAP_AW-1:0]] <= item_s1.rx_byte;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && ctl.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && ctl.emit) out_q <= result;
	end

	// position never leaves the capture range
	assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < 6'(tpd_pkg::MAX_PACKET_BYTES))
		else $error("byte position out of range");

	// a partial identity or key packet stays inside its template
	assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q != '0 && tmpl_q == tpd_pkg::TT_KEYS) |-> pos_q == 5'd1)
		else $error("key packet position past first byte");

	assert property (@(posedge clk) disable iff (!arst_n)
		(tmpl_q == tpd_pkg::TT_IDENTITY) |-> pos_q < tpd_pkg::IDENT_LEN)
		else $error("identity packet position past template end");

	// a timeout clears the partial packet
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && item_s1.kind) |=> pos_q == '0)
		else $error("timeout did not drop partial packet");

	// a completed packet restarts parsing and offers a result
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && ctl.emit) |=> (pos_q == '0 && out_valid_q))
		else $error("completed packet not delivered");

endmodule

FILE: tb/template_packet_deframer_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// template_packet_deframer_core_test
// Self-checking bench for the template packet deframer. Directed byte
// sequences hit the start-byte rules, key extremes, drops and timeouts. After
// that, random phases run under both protocol variants. Most of the random
// traffic is well-formed identity, routing and key packets with random
// content; the rest is broken packets, timeouts and noise. Both handshakes
// idle at random, except for one phase that runs at full rate. A scoreboard
// predicts every packet and checks each result transfer field by field.
// ----------------------------------------------------------------------------
module template_packet_deframer_core_test;

	localparam logic KIND_BYTE    = 1'b0;
	localparam logic KIND_TIMEOUT = 1'b1;

	localparam int STALL_LIMIT  = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int PHASE_ITEMS  = 200;

	// template element codes: exact bytes below, wildcards above
	localparam logic [8:0] PAT_ANY   = 9'h100;
	localparam logic [8:0] PAT_DIGIT = 9'h101;
	localparam logic [8:0] PAT_KEY   = 9'h102;

	localparam logic [8:0] OLD_ID_PAT [12] = '{
		9'h000, 9'h005, 9'h028, 9'h008, 9'h076, PAT_DIGIT, 9'h02E, PAT_DIGIT,
		9'h001, 9'h001, 9'h001, 9'h001
	};
	localparam logic [8:0] NEW_ID_PAT [12] = '{
		9'h073, 9'h065, 9'h069, 9'h06B, 9'h061, PAT_DIGIT,
		9'h020, 9'h076, PAT_DIGIT, 9'h02E, PAT_DIGIT, PAT_DIGIT
	};
	localparam logic [8:0] ROUTE_PAT [24] = '{
		9'h000, 9'h008, 9'h009, 9'h000, 9'h000, 9'h000, 9'h000,
		PAT_ANY, PAT_ANY, PAT_ANY, PAT_ANY, PAT_ANY,
		9'h000, 9'h008, 9'h009, 9'h000, 9'h000, 9'h000, 9'h000,
		9'h000, 9'h000, 9'h000, 9'h000, 9'h000
	};

	// Packet predictor and queue of expected packet results
	class deframe_scoreboard;
		logic                 variant = 1'b0;
		logic [4:0]           pos = 5'd0;
		tpd_pkg::template_t   cur_tmpl = tpd_pkg::TT_IDENTITY;
		logic [7:0]           captured [tpd_pkg::MAX_PACKET_BYTES];
		tpd_pkg::out_item_t   packet_q [$];
		int                   errors = 0;

		function int length_of(tpd_pkg::template_t t);
			if (t == tpd_pkg::TT_KEYS) return 2;
			if (t == tpd_pkg::TT_ROUTING) return 24;
			return 12;
		endfunction

		function logic [8:0] pattern_at(tpd_pkg::template_t t, logic [4:0] p);
			if (p >= length_of(t)) return PAT_ANY;
			case (t)
				tpd_pkg::TT_KEYS:    return PAT_KEY;
				tpd_pkg::TT_ROUTING: return ROUTE_PAT[p];
				default:    return variant ? NEW_ID_PAT[p[3:0]] : OLD_ID_PAT[p[3:0]];
			endcase
		endfunction

		function logic fits(tpd_pkg::template_t t, logic [4:0] p, logic [7:0] b);
			logic [8:0] e;
			e = pattern_at(t, p);
			case (e)
				PAT_ANY:   return 1'b1;
				PAT_DIGIT: return b >= 8'h30 && b <= 8'h39;
				PAT_KEY:   return b[7:5] == 3'b111;
				default:   return b == e[7:0];
			endcase
		endfunction

		function logic [3:0] dec(logic [7:0] c);
			return (c >= 8'h30 && c <= 8'h39) ? c[3:0] : 4'h0;
		endfunction

		function int pending();
			return packet_q.size();
		endfunction

		// Advance the parser by one accepted item; queue a packet if one completes
		function void note_input(tpd_pkg::in_item_t it);
			logic [7:0]         b;
			tpd_pkg::template_t t;
			logic               ok;
			tpd_pkg::out_item_t r;
			b = it.rx_byte;
			t = cur_tmpl;
			if (it.kind == KIND_TIMEOUT) begin
				pos = 5'd0;
				return;
			end
			if (pos != 5'd0) begin
				ok = fits(t, pos, b);
				// second identity byte off: retry in the variant's alternate template
				if (!ok && pos == 5'd1 && t == tpd_pkg::TT_IDENTITY) begin
					t = variant ? tpd_pkg::TT_KEYS : tpd_pkg::TT_ROUTING;
					cur_tmpl = t;
					ok = fits(t, pos, b);
				end
				if (!ok) pos = 5'd0;
			end
			if (pos == 5'd0) begin
				if ({1'b0, b} == pattern_at(tpd_pkg::TT_IDENTITY, 5'd0))
					t = tpd_pkg::TT_IDENTITY;
				else if (b == 8'h00) t = tpd_pkg::TT_ROUTING;
				else if (b[7:5] == 3'b011) t = tpd_pkg::TT_KEYS;
				else return;
				cur_tmpl = t;
			end
			if (pos < tpd_pkg::MAX_PACKET_BYTES) captured[pos] = b;
			pos = pos + 5'd1;
			if (pos < length_of(t)) return;
			pos = 5'd0;

			r = '0;
			r.packet_type = t;
			r.cell_count = 8'd40;
			if (t == tpd_pkg::TT_KEYS) begin
				r.key_bits = {captured[1][4:0], 3'b000, captured[0][4:0]};
			end else if (t == tpd_pkg::TT_ROUTING) begin
				r.routing_bits = {captured[11], captured[10], captured[9],
					captured[8], captured[7]};
			end else if (variant) begin
				r.firmware_version = {dec(captured[8]), dec(captured[10]), dec(captured[11])};
				r.model_number = dec(captured[5]);
			end else begin
				r.firmware_version = {dec(captured[5]), dec(captured[7]), 4'h0};
				r.cell_count = captured[2];
			end
			packet_q.push_back(r);
		endfunction

		function void report(string what, tpd_pkg::out_item_t want,
			tpd_pkg::out_item_t got);
			errors++;
			if (errors <= 10) begin
				$display("%0t %s", $realtime, what);
				$display("  want type=%0d key=%h route=%h fw=%h model=%h cells=%h",
					want.packet_type, want.key_bits, want.routing_bits,
					want.firmware_version, want.model_number, want.cell_count);
				$display("  got  type=%0d key=%h route=%h fw=%h model=%h cells=%h",
					got.packet_type, got.key_bits, got.routing_bits,
					got.firmware_version, got.model_number, got.cell_count);
			end
		endfunction

		// Compare one result transfer with the oldest expected packet
		function void check_result(tpd_pkg::out_item_t got);
			tpd_pkg::out_item_t want;
			if (packet_q.size() == 0) begin
				report("result with no packet expected", '0, got);
				return;
			end
			want = packet_q.pop_front();
			if (got.packet_type !== want.packet_type || got.key_bits !== want.key_bits ||
				got.routing_bits !== want.routing_bits ||
				got.firmware_version !== want.firmware_version ||
				got.model_number !== want.model_number ||
				got.cell_count !== want.cell_count)
				report("packet result mismatch", want, got);
		endfunction
	endclass

	logic               clk;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               in_ready;
	tpd_pkg::in_item_t  in_data   = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	tpd_pkg::out_item_t out_data;
	logic               cfg_we    = 1'b0;
	logic               cfg_wdata = 1'b0;

	bit  burst = 1'b0;
	int  stall_cycles = 0;
	logic [7:0] pkt [$];

	deframe_scoreboard sb = new();

	template_packet_deframer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Observe transfers on both sides, stall the receiver, watch for a hang
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			if (in_valid && in_ready) sb.note_input(in_data);
			out_ready <= burst ? 1'b1 : ($urandom_range(99) >= 38);
			if ((out_valid && out_ready) || (in_valid && in_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("template_packet_deframer_core_test NOT OK");
				$finish;
			end
		end
	end

	// Present one item and hold it until its transfer
	task automatic send_item(input tpd_pkg::in_item_t it);
		while (!burst && $urandom_range(99) < 38) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_byte(input logic [7:0] b);
		send_item('{kind: KIND_BYTE, rx_byte: b});
	endtask

	task automatic send_timeout();
		send_item('{kind: KIND_TIMEOUT, rx_byte: 8'($urandom_range(255))});
	endtask

	// Hold the sender until every expected packet is out and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_variant(input logic v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.variant = v;
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'h30 + 8'($urandom_range(9));
	endfunction

	// Build a well-formed packet: 0 identity, 1 routing, 2 keys
	task automatic build_packet(input int which, input logic v);
		pkt.delete();
		case (which)
			0: begin
				if (v)
					pkt = '{8'h73, 8'h65, 8'h69, 8'h6B, 8'h61, rand_digit(),
						8'h20, 8'h76, rand_digit(), 8'h2E, rand_digit(), rand_digit()};
				else
					pkt = '{8'h00, 8'h05, 8'h28, 8'h08, 8'h76, rand_digit(),
						8'h2E, rand_digit(), 8'h01, 8'h01, 8'h01, 8'h01};
			end
			1: begin
				pkt = '{8'h00, 8'h08, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00};
				repeat (5) pkt.push_back(8'($urandom_range(255)));
				pkt.push_back(8'h00);
				pkt.push_back(8'h08);
				pkt.push_back(8'h09);
				repeat (9) pkt.push_back(8'h00);
			end
			default: begin
				pkt.push_back({3'b011, 5'($urandom_range(31))});
				pkt.push_back({3'b111, 5'($urandom_range(31))});
			end
		endcase
	endtask

	// One random stretch of traffic; returns the items that count
	task automatic random_chunk(output int counted);
		int   r;
		int   cut;
		logic v;
		r = $urandom_range(99);
		counted = 0;
		if (r < 60) begin
			build_packet($urandom_range(2), sb.variant);
			foreach (pkt[i]) send_byte(pkt[i]);
			counted = pkt.size();
		end else if (r < 78) begin
			// truncate or corrupt a packet, sometimes the other variant's identity
			v = ($urandom_range(3) == 0) ? ~sb.variant : sb.variant;
			build_packet($urandom_range(2), v);
			cut = $urandom_range(pkt.size() - 1);
			if ($urandom_range(1)) pkt[cut] = 8'($urandom_range(255));
			else pkt = pkt[0:(cut == 0 ? 0 : cut - 1)];
			foreach (pkt[i]) send_byte(pkt[i]);
			if ($urandom_range(1)) send_timeout();
			counted = pkt.size();
		end else if (r < 86) begin
			send_timeout();
			counted = 1;
		end else begin
			repeat ($urandom_range(4, 1)) send_byte(8'($urandom_range(255)));
		end
		if ($urandom_range(49) == 0) drain();
	endtask

	initial begin
		int phase_count;
		int got;
		logic phase_variant [4];

		phase_variant = '{1'b1, 1'b0, 1'b1, 1'b0};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Key extremes under the reset variant
		send_byte(8'h60); send_byte(8'hE0);
		send_byte(8'h7F); send_byte(8'hFF);
		// bytes that cannot start a packet
		send_byte(8'hFF); send_byte(8'h80);
		// timeout drops a partial packet
		send_byte(8'h61); send_timeout();
		// mismatch drops, the failing byte is ignored
		send_byte(8'h62); send_byte(8'h05);
		// mismatch drops, the failing byte restarts a packet
		send_byte(8'h64); send_byte(8'h64); send_byte(8'hE5);
		send_byte(8'h63); send_byte(8'h00); send_timeout();
		// identity mismatch deep in the packet
		send_byte(8'h00); send_byte(8'h05); send_byte(8'h28); send_byte(8'h10);

		// Random phases across both variants; one phase runs without idling
		foreach (phase_variant[p]) begin
			set_variant(phase_variant[p]);
			burst = (p == 2);
			phase_count = 0;
			while (phase_count < PHASE_ITEMS) begin
				random_chunk(got);
				phase_count += got;
			end
		end
		burst = 1'b0;

		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("template_packet_deframer_core_test OK");
		else
			$display("template_packet_deframer_core_test NOT OK");
		$finish;
	end

endmodule
